[hw/rtl/tsc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the table stream cipher
// no dependencies
package tsc_pkg;

   localparam int KeyBytes   = 32;
   localparam int NonceBytes = 8;
   localparam int TableDepth = 256;
   localparam int KeyWords   = 4;
   localparam int KeyIdxW    = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
   localparam int NonceIdxW  = (NonceBytes > 1) ? $clog2(NonceBytes) : 1;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int CsrAddrW   = 3;

   localparam logic [AddrW-1:0] KeyLast    = AddrW'(KeyBytes - 1);
   localparam logic [AddrW-1:0] NonceLast  = AddrW'(NonceBytes - 1);
   localparam logic [AddrW-1:0] SpreadLast = AddrW'(TableDepth - KeyBytes - 1);
   localparam logic [AddrW-1:0] FullLast   = AddrW'(TableDepth - 1);
   localparam logic [AddrW-1:0] HalfKey    = AddrW'(KeyBytes / 2);
   localparam logic [AddrW-1:0] KeyOffset  = AddrW'(KeyBytes);
   localparam logic [KeyIdxW-1:0] FoldIdxLast = KeyIdxW'(KeyBytes - 1);

   localparam logic [CsrAddrW-1:0] CsrKey0  = 3'd0;
   localparam logic [CsrAddrW-1:0] CsrKey1  = 3'd1;
   localparam logic [CsrAddrW-1:0] CsrKey2  = 3'd2;
   localparam logic [CsrAddrW-1:0] CsrKey3  = 3'd3;
   localparam logic [CsrAddrW-1:0] CsrNonce = 3'd4;

   localparam logic CmdRekey = 1'b0;
   localparam logic CmdData  = 1'b1;

   typedef struct packed {
      logic go;
      logic rekey;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } res_type;

endpackage

[hw/rtl/tsc_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module tsc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/tsc_engine.sv]
`timescale 1ns / 1ps
// key schedule and data sequencer around the table ram
// depends on tsc_pkg and tsc_ram
module tsc_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  tsc_pkg::cmd_type            cmd,
   input  logic [7:0]                  din,
   input  logic [8*tsc_pkg::KeyWords*8-1:0] key_bits,
   input  logic [63:0]                 nonce_bits,
   output logic                        busy,
   output tsc_pkg::res_type            res
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RDA  = 4'b0010,
      ST_RDB  = 4'b0100,
      ST_EXEC = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      P_KEY, P_FOLD1, P_NONCE, P_FOLD2, P_SPREAD, P_MIX, P_DATA
   } pass_type;

   localparam int AW = tsc_pkg::AddrW;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   logic [AW-1:0] c_ff, c_in;
   logic [tsc_pkg::KeyIdxW-1:0] fidx_ff, fidx_in;
   logic [7:0] mix_ff, mix_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [7:0] ta_ff, ta_in;
   logic [7:0] din_ff, din_in;
   logic [AW-1:0] rd_addr_ff;
   logic [tsc_pkg::TableDepth-1:0] valid_ff, valid_in;

   logic [AW-1:0] addr_a, addr_b, raddr, waddr, last_c, cterm;
   logic [7:0] rdata, rd_masked, extra, t, mix_new;
   logic use_b, add_mix, we, last_step;

   tsc_ram #(.Width(8), .Depth(tsc_pkg::TableDepth)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (t),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd_masked = valid_ff[rd_addr_ff] ? rdata : 8'd0;

   // per-pass addressing and operand selection
   always_comb begin
      addr_a  = c_ff;
      addr_b  = c_ff;
      waddr   = c_ff;
      extra   = 8'd0;
      use_b   = 1'b0;
      add_mix = 1'b0;
      cterm   = '0;
      last_c  = tsc_pkg::FullLast;
      case (pass_ff)
         P_KEY: begin
            extra  = key_bits[8*c_ff[tsc_pkg::KeyIdxW-1:0] +: 8];
            last_c = tsc_pkg::KeyLast;
         end
         P_NONCE: begin
            extra  = nonce_bits[8*c_ff[tsc_pkg::NonceIdxW-1:0] +: 8];
            last_c = tsc_pkg::NonceLast;
         end
         P_FOLD1, P_FOLD2: begin
            addr_a  = AW'(fidx_ff);
            waddr   = AW'(fidx_ff);
            add_mix = 1'b1;
            cterm   = c_ff;
         end
         P_SPREAD: begin
            addr_b  = (c_ff == tsc_pkg::SpreadLast) ? '0 : c_ff + 1'b1;
            waddr   = c_ff + tsc_pkg::KeyOffset;
            use_b   = 1'b1;
            add_mix = 1'b1;
            cterm   = c_ff;
            last_c  = tsc_pkg::SpreadLast;
         end
         P_MIX: begin
            addr_b  = c_ff + tsc_pkg::HalfKey;
            use_b   = 1'b1;
            add_mix = 1'b1;
            cterm   = c_ff;
         end
         P_DATA: begin
            addr_a  = pos_ff;
            addr_b  = pos_ff + 1'b1;
            waddr   = pos_ff;
            use_b   = 1'b1;
            add_mix = 1'b1;
            cterm   = pos_ff;
         end
         default: ;
      endcase
   end

   assign raddr = (state_ff == ST_RDB) ? addr_b : addr_a;
   assign t = ta_ff + (use_b ? rd_masked : 8'd0) + (add_mix ? mix_ff : 8'd0) + extra;
   assign mix_new = mix_ff + ((pass_ff == P_SPREAD) ? ta_ff : t) + cterm;
   assign we = (state_ff == ST_EXEC);
   assign last_step = (c_ff == last_c);

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      c_in      = c_ff;
      fidx_in   = fidx_ff;
      mix_in    = mix_ff;
      pos_in    = pos_ff;
      ta_in     = ta_ff;
      din_in    = din_ff;
      valid_in  = valid_ff;
      res.valid = 1'b0;
      res.data  = din_ff ^ ((mix_new + t) ^ t);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.go) begin
               state_in = ST_RDA;
               din_in   = din;
               c_in     = '0;
               fidx_in  = '0;
               if (cmd.rekey) begin
                  pass_in  = P_KEY;
                  valid_in = '0;
                  mix_in   = 8'd0;
                  pos_in   = '0;
               end else begin
                  pass_in = P_DATA;
               end
            end
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: begin
            ta_in    = rd_masked;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            valid_in[waddr] = 1'b1;
            mix_in   = mix_new;
            state_in = ST_RDA;
            c_in     = c_ff + 1'b1;
            fidx_in  = (fidx_ff == tsc_pkg::FoldIdxLast) ? '0 : fidx_ff + 1'b1;
            if (pass_ff == P_DATA) begin
               res.valid = 1'b1;
               pos_in    = pos_ff + 1'b1;
               state_in  = ST_IDLE;
            end else if (last_step) begin
               c_in    = '0;
               fidx_in = '0;
               case (pass_ff)
                  P_KEY:    pass_in = P_FOLD1;
                  P_FOLD1:  pass_in = P_NONCE;
                  P_NONCE:  pass_in = P_FOLD2;
                  P_FOLD2:  pass_in = P_SPREAD;
                  P_SPREAD: pass_in = P_MIX;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= P_DATA;
         c_ff     <= '0;
         fidx_ff  <= '0;
         mix_ff   <= 8'd0;
         pos_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         c_ff     <= c_in;
         fidx_ff  <= fidx_in;
         mix_ff   <= mix_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
      ta_ff      <= ta_in;
      din_ff     <= din_in;
      rd_addr_ff <= raddr;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hw/rtl/table_stream_cipher_256_top.sv]
`timescale 1ns / 1ps
// top level: stream channels, key and nonce registers, result register
// depends on tsc_pkg and tsc_engine
//
// channel  direction  content
// req_     in         tdata = data_in[7:0], tuser = cmd
// rsp_     out        tdata = data_out[7:0]
// csr_     in         we, addr[2:0], wdata[63:0]
//
// a data transaction runs through the engine states RDA, RDB and EXEC: two table reads
// through the single ram read port, then the add and write-back; the result is loaded
// into the output register at the end of EXEC, and the engine then returns to idle.
// a rekey steps the same three states through the key, fold, nonce, fold, spread
// and mix passes; table clearing on reset and rekey is immediate.
// reset is synchronous; the next request is taken only once the engine is idle
// and the result register is free or being drained.
module table_stream_cipher_256_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_in[7:0]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_out[7:0]
   input  logic        csr_we,
   input  logic [tsc_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [63:0] csr_wdata
);

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        busy;
   tsc_pkg::cmd_type cmd;
   tsc_pkg::res_type res;

   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign cmd.go     = req_tvalid && req_tready;
   assign cmd.rekey  = (req_tuser == tsc_pkg::CmdRekey);

   tsc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .din        (req_tdata),
      .key_bits   ({key3_ff, key2_ff, key1_ff, key0_ff}),
      .nonce_bits (nonce_ff),
      .busy       (busy),
      .res        (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         nonce_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               tsc_pkg::CsrKey0:  key0_ff  <= csr_wdata;
               tsc_pkg::CsrKey1:  key1_ff  <= csr_wdata;
               tsc_pkg::CsrKey2:  key2_ff  <= csr_wdata;
               tsc_pkg::CsrKey3:  key3_ff  <= csr_wdata;
               tsc_pkg::CsrNonce: nonce_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sim/tb_table_stream_cipher_256_top.sv]
`timescale 1ns / 1ps
// testbench for table_stream_cipher_256_top: directed table then random byte stream,
// checked against an in-bench model of the cipher state; depends on tsc_pkg and the rtl
module tb_table_stream_cipher_256_top;
   import tsc_pkg::*;

   localparam int RekeyCycles = 3300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [63:0] csr_wdata = '0;

   table_stream_cipher_256_top dut (.*);

   always #6 clock = ~clock;

   // cipher model state
   logic [63:0] key_regs [KeyWords];
   logic [63:0] nonce_reg;
   logic [7:0]  sbox [TableDepth];
   logic [7:0]  mix;
   logic [7:0]  pos;

   logic [7:0] cipher_bytes_due [$];
   int errors = 0;
   bit long_hold = 0;

   typedef struct {
      logic       cmd;
      logic [7:0] data;
      bit         known;
      logic [7:0] result;
   } stim_row;

   function automatic logic [7:0] key_at(int i);
      return key_regs[(i >> 3) & 3][(i & 7) * 8 +: 8];
   endfunction

   function automatic void fold_table();
      for (int c = 0; c < 256; c++) begin
         int ix;
         ix = c % KeyBytes;
         sbox[ix] = sbox[ix] + mix;
         mix = mix + sbox[ix] + 8'(c);
      end
   endfunction

   function automatic void schedule_key();
      int diff;
      diff = 256 - KeyBytes;
      foreach (sbox[i]) sbox[i] = '0;
      mix = '0;
      pos = '0;
      for (int c = 0; c < KeyBytes; c++) begin
         sbox[c] = sbox[c] + key_at(c);
         mix = mix + sbox[c];
      end
      fold_table();
      for (int c = 0; c < NonceBytes; c++) begin
         sbox[c] = sbox[c] + nonce_reg[c * 8 +: 8];
         mix = mix + sbox[c];
      end
      fold_table();
      for (int c = 0; c < diff; c++) begin
         sbox[(c + KeyBytes) & 255] = sbox[c] + sbox[(c + 1) % diff] + mix;
         mix = mix + sbox[c % diff] + 8'(c);
      end
      for (int c = 0; c < 256; c++) begin
         sbox[c] = sbox[c] + sbox[(c + KeyBytes / 2) & 255] + mix;
         mix = mix + sbox[c] + 8'(c);
      end
   endfunction

   // returns 1 and the output byte when the item gives a result
   function automatic bit cipher_step(logic cmd, logic [7:0] din, output logic [7:0] dout);
      logic [7:0] t;
      dout = '0;
      if (cmd == CmdRekey) begin
         schedule_key();
         return 0;
      end
      sbox[pos] = sbox[pos] + sbox[pos + 8'd1] + mix;
      t = sbox[pos];
      mix = mix + t + pos;
      dout = din ^ ((mix + t) ^ t);
      pos = pos + 8'd1;
      return 1;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(logic [CsrAddrW-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx < CsrNonce) key_regs[idx] = val;
      else if (idx == CsrNonce) nonce_reg = val;
   endtask

   // waits for outstanding bytes, then for a rekey still running
   task automatic drain_and_settle();
      while (cipher_bytes_due.size() != 0) @(negedge clock);
      idle_cycles(RekeyCycles);
   endtask

   // typed rows expect their typed value, all others the predicted one
   task automatic send_item(logic cmd, logic [7:0] din, bit check_known, logic [7:0] known);
      logic [7:0] dout;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= din;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cipher_step(cmd, din, dout)) begin
         if (check_known) cipher_bytes_due.push_back(known);
         else cipher_bytes_due.push_back(dout);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic load_keys(logic [63:0] k0, k1, k2, k3, n);
      write_reg(CsrKey0, k0);
      write_reg(CsrKey1, k1);
      write_reg(CsrKey2, k2);
      write_reg(CsrKey3, k3);
      write_reg(CsrNonce, n);
   endtask

   task automatic random_phase(int items);
      int g;
      for (int i = 0; i < items; i++) begin
         g = gap_len();
         if (g > 0) idle_cycles(g);
         // rekeys are rare since each runs the whole key schedule
         if ($urandom_range(0, 199) == 0) send_item(CmdRekey, 8'($urandom), 0, '0);
         else send_item(CmdData, 8'($urandom), 0, '0);
      end
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (60) @(negedge clock);
            long_hold = 0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_bytes_due.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual %02h", $time, rsp_tdata);
            errors++;
         end else begin
            logic [7:0] want;
            want = cipher_bytes_due.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t data_out mismatch: expected %02h, actual %02h",
                        $time, want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row rows [$];
      stim_row r;
      for (int i = 0; i < KeyWords; i++) key_regs[i] = '0;
      nonce_reg = '0;
      foreach (sbox[i]) sbox[i] = '0;
      mix = '0;
      pos = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: all-zero table gives keystream 0 for the first byte
      rows.push_back('{CmdData, 8'h00, 1, 8'h00});
      rows.push_back('{CmdData, 8'hff, 0, '0});
      rows.push_back('{CmdData, 8'h5a, 0, '0});
      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.cmd, r.data, r.known, r.result);
      end
      drain_and_settle();

      // extremes of the key registers, out-of-range index ignored
      load_keys('1, '1, '1, '1, '1);
      write_reg(3'd7, 64'hdead_beef_0123_4567);
      write_reg(3'd5, '1);
      rows = {};
      rows.push_back('{CmdRekey, 8'hff, 0, '0});
      rows.push_back('{CmdData, 8'h00, 0, '0});
      rows.push_back('{CmdData, 8'hff, 0, '0});
      rows.push_back('{CmdRekey, 8'h00, 0, '0});
      rows.push_back('{CmdData, 8'h80, 0, '0});
      rows.push_back('{CmdData, 8'h01, 0, '0});
      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.cmd, r.data, r.known, r.result);
      end
      drain_and_settle();

      // write after the last rekey only matters at the next one
      load_keys('0, '0, '0, '0, '0);
      send_item(CmdData, 8'h33, 0, '0);
      send_item(CmdRekey, 8'h00, 0, '0);
      send_item(CmdData, 8'hc3, 0, '0);
      drain_and_settle();

      // random settings, byte stream crosses the position wraparound
      for (int ph = 0; ph < 3; ph++) begin
         load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
         send_item(CmdRekey, 8'($urandom), 0, '0);
         if (ph == 1) long_hold = 1;
         random_phase(575);
         drain_and_settle();
      end

      while (cipher_bytes_due.size() != 0) @(negedge clock);
      idle_cycles(50);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ram.sv
hw/rtl/tsc_engine.sv
hw/rtl/table_stream_cipher_256_top.sv
sim/tb_table_stream_cipher_256_top.sv
